// File: sv/bpnfa_pkg.sv
// Shared types and constants for the bit-parallel NFA matcher.
// No dependencies; used by every module of the block.
package bpnfa_pkg;

   // Field widths fixed by the request and response format
   localparam int FUNC_W   = 3;
   localparam int STATE_W  = 8;
   localparam int SYMBOL_W = 4;

   // One word of a state set
   localparam int WORD_BITS = 64;

   // Default automaton size
   localparam int MAX_STATES_DEF    = 256;
   localparam int ALPHABET_SIZE_DEF = 16;

   // Request function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_SET_TRANS = 3'd0,
      FUNC_SET_INIT  = 3'd1,
      FUNC_SET_FINAL = 3'd2,
      FUNC_CLEAR_ALL = 3'd3,
      FUNC_START     = 3'd4,
      FUNC_SYMBOL    = 3'd5,
      FUNC_END       = 3'd6
   } func_type;

   // Result handed from the engine to the response register
   typedef struct packed {
      logic match;
      logic any_active;
   } result_type;

endpackage

// File: sv/bpnfa_succ_mem.sv
// Successor table memory: one 64-bit set word per entry, one write and one read port.
// Read data is registered. Depends on bpnfa_pkg.
module bpnfa_succ_mem #(
   parameter int DEPTH = 16384,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [AW-1:0]                    wr_addr,
   input  logic [bpnfa_pkg::WORD_BITS-1:0]  wr_data,
   input  logic                             rd_en,
   input  logic [AW-1:0]                    rd_addr,
   output logic [bpnfa_pkg::WORD_BITS-1:0]  rd_data
);

   logic [bpnfa_pkg::WORD_BITS-1:0] mem [DEPTH];
   logic [bpnfa_pkg::WORD_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bpnfa_engine.sv
// Sequencer of the NFA matcher: holds the initial, final and current sets and
// drives the successor memory (clear sweep, read-modify-write, symbol scan).
// Depends on bpnfa_pkg; the memory itself sits in bpnfa_succ_mem.
module bpnfa_engine #(
   parameter int MAX_STATES    = bpnfa_pkg::MAX_STATES_DEF,
   parameter int ALPHABET_SIZE = bpnfa_pkg::ALPHABET_SIZE_DEF,
   localparam int WORDS = (MAX_STATES + bpnfa_pkg::WORD_BITS - 1) / bpnfa_pkg::WORD_BITS,
   localparam int DEPTH = MAX_STATES * ALPHABET_SIZE * WORDS,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   // request side
   input  logic                                req_valid,
   output logic                                idle,
   input  logic [bpnfa_pkg::FUNC_W-1:0]        req_func,
   input  logic [bpnfa_pkg::STATE_W-1:0]       req_state_a,
   input  logic [bpnfa_pkg::STATE_W-1:0]       req_state_b,
   input  logic [bpnfa_pkg::SYMBOL_W-1:0]      req_symbol,
   // result side
   input  logic                                slot_free,
   output logic                                done,
   output bpnfa_pkg::result_type               result,
   // successor memory
   output logic                                mem_wr_en,
   output logic [AW-1:0]                       mem_wr_addr,
   output logic [bpnfa_pkg::WORD_BITS-1:0]     mem_wr_data,
   output logic                                mem_rd_en,
   output logic [AW-1:0]                       mem_rd_addr,
   input  logic [bpnfa_pkg::WORD_BITS-1:0]     mem_rd_data
);

   localparam int SET_BITS = WORDS * bpnfa_pkg::WORD_BITS;
   localparam int SW       = $clog2(SET_BITS);
   localparam int WW       = (WORDS > 1) ? $clog2(WORDS) : 1;

   typedef logic [WORDS-1:0][bpnfa_pkg::WORD_BITS-1:0] set_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_T_RD,
      ST_T_WR,
      ST_STEP,
      ST_DRAIN,
      ST_MATCH,
      ST_FINISH
   } state_type;

   state_type                        state_ff, state_in;
   logic [bpnfa_pkg::STATE_W-1:0]    sa_ff, sa_in, sb_ff, sb_in;
   logic [bpnfa_pkg::SYMBOL_W-1:0]   sym_ff, sym_in;
   set_type                          init_ff, init_in, fin_ff, fin_in;
   set_type                          cur_ff, cur_in, nxt_ff, nxt_in;
   logic                             init_any_ff, init_any_in;
   logic                             cur_any_ff, cur_any_in;
   logic                             nxt_any_ff, nxt_any_in;
   logic                             match_ff, match_in;
   logic [AW-1:0]                    clr_cnt_ff, clr_cnt_in;
   logic                             clr_res_ff, clr_res_in;
   logic [SW-1:0]                    scan_s_ff, scan_s_in;
   logic [WW-1:0]                    scan_k_ff, scan_k_in;
   logic                             rdv_ff, rdv_in;
   logic [WW-1:0]                    rdk_ff, rdk_in;

   logic [SET_BITS-1:0]              cur_bits;
   logic [WW-1:0]                    req_a_word;
   logic [WW-1:0]                    sb_word;
   logic                             scan_active;
   logic                             scan_last_s;
   logic                             scan_last_k;
   logic [AW-1:0]                    trans_addr;
   logic [AW-1:0]                    step_addr;

   assign cur_bits    = cur_ff;
   assign req_a_word  = WW'(req_state_a[7:6]);
   assign sb_word     = WW'(sb_ff[7:6]);
   assign scan_active = cur_bits[scan_s_ff];
   assign scan_last_s = (int'(scan_s_ff) == MAX_STATES - 1);
   assign scan_last_k = (int'(scan_k_ff) == WORDS - 1);

   // Word address of a successor row: (state * alphabet + symbol) * words + word
   assign trans_addr = AW'((int'(sa_ff) * ALPHABET_SIZE + int'(sym_ff)) * WORDS
                           + int'(sb_word));
   assign step_addr  = AW'((int'(scan_s_ff) * ALPHABET_SIZE + int'(sym_ff)) * WORDS
                           + int'(scan_k_ff));

   assign idle   = (state_ff == ST_IDLE);
   assign result = '{match: match_ff, any_active: cur_any_ff};

   // Next-state and datapath logic
   always_comb begin
      state_in    = state_ff;
      sa_in       = sa_ff;
      sb_in       = sb_ff;
      sym_in      = sym_ff;
      init_in     = init_ff;
      fin_in      = fin_ff;
      cur_in      = cur_ff;
      nxt_in      = nxt_ff;
      init_any_in = init_any_ff;
      cur_any_in  = cur_any_ff;
      nxt_any_in  = nxt_any_ff;
      match_in    = match_ff;
      clr_cnt_in  = clr_cnt_ff;
      clr_res_in  = clr_res_ff;
      scan_s_in   = scan_s_ff;
      scan_k_in   = scan_k_ff;
      rdv_in      = 1'b0;
      rdk_in      = rdk_ff;
      done        = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = trans_addr;
      mem_wr_data = mem_rd_data | (bpnfa_pkg::WORD_BITS'(1) << sb_ff[5:0]);
      mem_rd_en   = 1'b0;
      mem_rd_addr = trans_addr;

      // Fold a returning successor word into the next set
      if (rdv_ff) begin
         nxt_in[rdk_ff] = nxt_ff[rdk_ff] | mem_rd_data;
         nxt_any_in     = nxt_any_ff | (|mem_rd_data);
      end

      unique case (state_ff)
         // zero the successor table, one word per cycle
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = '0;
            if (int'(clr_cnt_ff) == DEPTH - 1) begin
               state_in = clr_res_ff ? ST_FINISH : ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               sa_in    = req_state_a;
               sb_in    = req_state_b;
               sym_in   = req_symbol;
               match_in = 1'b0;
               state_in = ST_FINISH;
               unique case (bpnfa_pkg::func_type'(req_func))
                  bpnfa_pkg::FUNC_SET_TRANS: begin
                     if (int'(req_state_a) < MAX_STATES && int'(req_state_b) < MAX_STATES
                         && int'(req_symbol) < ALPHABET_SIZE) begin
                        state_in = ST_T_RD;
                     end
                  end
                  bpnfa_pkg::FUNC_SET_INIT: begin
                     if (int'(req_state_a) < MAX_STATES) begin
                        init_in[req_a_word][req_state_a[5:0]] = 1'b1;
                        init_any_in = 1'b1;
                     end
                  end
                  bpnfa_pkg::FUNC_SET_FINAL: begin
                     if (int'(req_state_a) < MAX_STATES) begin
                        fin_in[req_a_word][req_state_a[5:0]] = 1'b1;
                     end
                  end
                  bpnfa_pkg::FUNC_CLEAR_ALL: begin
                     init_in     = '0;
                     fin_in      = '0;
                     cur_in      = '0;
                     init_any_in = 1'b0;
                     cur_any_in  = 1'b0;
                     clr_cnt_in  = '0;
                     clr_res_in  = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  bpnfa_pkg::FUNC_START: begin
                     cur_in     = init_ff;
                     cur_any_in = init_any_ff;
                  end
                  bpnfa_pkg::FUNC_SYMBOL: begin
                     if (int'(req_symbol) < ALPHABET_SIZE) begin
                        nxt_in     = '0;
                        nxt_any_in = 1'b0;
                        scan_s_in  = '0;
                        scan_k_in  = '0;
                        state_in   = ST_STEP;
                     end else begin
                        cur_in     = '0;
                        cur_any_in = 1'b0;
                     end
                  end
                  bpnfa_pkg::FUNC_END: begin
                     scan_k_in = '0;
                     state_in  = ST_MATCH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         // transition: read the row word, then write it back with the new bit
         ST_T_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_T_WR;
         end

         ST_T_WR: begin
            mem_wr_en = 1'b1;
            state_in  = ST_FINISH;
         end

         // walk all states; an active one issues one read per row word
         ST_STEP: begin
            mem_rd_addr = step_addr;
            if (scan_active) begin
               mem_rd_en = 1'b1;
               rdv_in    = 1'b1;
               rdk_in    = scan_k_ff;
            end
            if (scan_active && !scan_last_k) begin
               scan_k_in = scan_k_ff + WW'(1);
            end else begin
               scan_k_in = '0;
               if (scan_last_s) begin
                  state_in = ST_DRAIN;
               end else begin
                  scan_s_in = scan_s_ff + SW'(1);
               end
            end
         end

         // last read data arrives; commit the new current set
         ST_DRAIN: begin
            cur_in     = nxt_in;
            cur_any_in = nxt_any_in;
            state_in   = ST_FINISH;
         end

         // intersect current and final sets, one word per cycle
         ST_MATCH: begin
            if (|(cur_ff[scan_k_ff] & fin_ff[scan_k_ff])) begin
               match_in = 1'b1;
            end
            if (scan_last_k) begin
               state_in = ST_FINISH;
            end else begin
               scan_k_in = scan_k_ff + WW'(1);
            end
         end

         ST_FINISH: begin
            clr_res_in = 1'b0;
            if (slot_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         init_ff     <= '0;
         fin_ff      <= '0;
         cur_ff      <= '0;
         init_any_ff <= 1'b0;
         cur_any_ff  <= 1'b0;
         match_ff    <= 1'b0;
         clr_cnt_ff  <= '0;
         clr_res_ff  <= 1'b0;
         rdv_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         init_ff     <= init_in;
         fin_ff      <= fin_in;
         cur_ff      <= cur_in;
         init_any_ff <= init_any_in;
         cur_any_ff  <= cur_any_in;
         match_ff    <= match_in;
         clr_cnt_ff  <= clr_cnt_in;
         clr_res_ff  <= clr_res_in;
         rdv_ff      <= rdv_in;
      end
      sa_ff      <= sa_in;
      sb_ff      <= sb_in;
      sym_ff     <= sym_in;
      nxt_ff     <= nxt_in;
      nxt_any_ff <= nxt_any_in;
      scan_s_ff  <= scan_s_in;
      scan_k_ff  <= scan_k_in;
      rdk_ff     <= rdk_in;
   end

endmodule

// File: sv/bit_parallel_nfa_matcher_core.sv
// Top level of the bit-parallel NFA matcher: engine, successor memory and
// response register. Depends on bpnfa_pkg, bpnfa_engine and bpnfa_succ_mem.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   func, state_a, state_b, symbol
//   rsp_      out        rsp_valid/rsp_ready   match, any_active
//
// Set initial, set final and start act on registers only, and the unused code 7
// changes nothing; set transition reads the row word and writes it back; end
// intersects the current and final sets word by word; symbol walks every state and
// reads the row words of the active ones; the symbol scan is bound by the single
// read port of the successor memory. Clear-all sweeps all MAX_STATES * ALPHABET_SIZE * WORDS words.
// After reset a clearing pass over the same successor table runs
// with req_ready low.
// A finished response waits in the response register; the next request is
// taken meanwhile and stalls at its end until that register frees.
module bit_parallel_nfa_matcher_core #(
   parameter int MAX_STATES    = bpnfa_pkg::MAX_STATES_DEF,
   parameter int ALPHABET_SIZE = bpnfa_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bpnfa_pkg::FUNC_W-1:0]      req_func,
   input  logic [bpnfa_pkg::STATE_W-1:0]     req_state_a,
   input  logic [bpnfa_pkg::STATE_W-1:0]     req_state_b,
   input  logic [bpnfa_pkg::SYMBOL_W-1:0]    req_symbol,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_match,
   output logic                              rsp_any_active
);

   localparam int WORDS = (MAX_STATES + bpnfa_pkg::WORD_BITS - 1) / bpnfa_pkg::WORD_BITS;
   localparam int DEPTH = MAX_STATES * ALPHABET_SIZE * WORDS;
   localparam int AW    = $clog2(DEPTH);

   logic                            mem_wr_en;
   logic [AW-1:0]                   mem_wr_addr;
   logic [bpnfa_pkg::WORD_BITS-1:0] mem_wr_data;
   logic                            mem_rd_en;
   logic [AW-1:0]                   mem_rd_addr;
   logic [bpnfa_pkg::WORD_BITS-1:0] mem_rd_data;

   logic                            slot_free;
   logic                            done;
   bpnfa_pkg::result_type           result;

   logic                            rsp_valid_ff, rsp_valid_in;
   bpnfa_pkg::result_type           rsp_ff, rsp_in;

   bpnfa_engine #(
      .MAX_STATES    (MAX_STATES),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .idle        (req_ready),
      .req_func    (req_func),
      .req_state_a (req_state_a),
      .req_state_b (req_state_b),
      .req_symbol  (req_symbol),
      .slot_free   (slot_free),
      .done        (done),
      .result      (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   bpnfa_succ_mem #(
      .DEPTH (DEPTH)
   ) u_succ_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Response register: free when empty or being taken this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_match      = rsp_ff.match;
   assign rsp_any_active = rsp_ff.any_active;

endmodule

// File: sv/bpnfa_checker.sv
// Port-level checks for the bit-parallel NFA matcher, bound to the top level.
// Depends on bpnfa_pkg and bit_parallel_nfa_matcher_core.
module bpnfa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [bpnfa_pkg::FUNC_W-1:0]      req_func,
   input logic [bpnfa_pkg::STATE_W-1:0]     req_state_a,
   input logic [bpnfa_pkg::STATE_W-1:0]     req_state_b,
   input logic [bpnfa_pkg::SYMBOL_W-1:0]    req_symbol,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_match,
   input logic                              rsp_any_active
);

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match)
                                  && $stable(rsp_any_active))
      else $error("response changed while stalled");

   // a match needs a non-empty current set
   a_match_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match |-> rsp_any_active)
      else $error("match reported with empty current set");

   // the clearing pass after reset holds off requests
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during clearing pass");

   // one request in flight at a time
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken before first finished");

endmodule

bind bit_parallel_nfa_matcher_core bpnfa_checker u_bpnfa_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for bit_parallel_nfa_matcher_core: directed table, then random
// load/run episodes, every response checked against an in-bench NFA set predictor or a pinned table value.
// Depends on bpnfa_pkg and the RTL of the matcher core.
`timescale 1ns / 1ps

module tb_top;

   localparam int NSTATES = bpnfa_pkg::MAX_STATES_DEF;
   localparam int NSYMS   = bpnfa_pkg::ALPHABET_SIZE_DEF;

   // func code 7 is not in the package enum; the block must ignore it
   localparam logic [bpnfa_pkg::FUNC_W-1:0] FUNC_UNUSED = 3'd7;

   // Responses that can be read straight off the request sequence
   localparam bpnfa_pkg::result_type RES_EMPTY  = '{match: 1'b0, any_active: 1'b0};
   localparam bpnfa_pkg::result_type RES_ACTIVE = '{match: 1'b0, any_active: 1'b1};
   localparam bpnfa_pkg::result_type RES_HIT    = '{match: 1'b1, any_active: 1'b1};

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [bpnfa_pkg::FUNC_W-1:0]   req_func;
   logic [bpnfa_pkg::STATE_W-1:0]  req_state_a;
   logic [bpnfa_pkg::STATE_W-1:0]  req_state_b;
   logic [bpnfa_pkg::SYMBOL_W-1:0] req_symbol;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic                           rsp_match;
   logic                           rsp_any_active;

   bit_parallel_nfa_matcher_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_state_a    (req_state_a),
      .req_state_b    (req_state_b),
      .req_symbol     (req_symbol),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_match      (rsp_match),
      .rsp_any_active (rsp_any_active)
   );

   // Predictor copy of the automaton
   logic [NSTATES-1:0] succ_rows [NSTATES*NSYMS];
   logic [NSTATES-1:0] init_set;
   logic [NSTATES-1:0] final_set;
   logic [NSTATES-1:0] cur_set;

   bpnfa_pkg::result_type pending_rsp_q [$];

   // Pinned expectation for directed rows, held with the request
   bit                    pin_flag;
   bpnfa_pkg::result_type pin_want;

   int send_idle_pct;
   int rcv_idle_pct;
   int sent_count;
   int fail_count;
   int n_requests;
   int n_responses;
   int n_sym_steps;
   int n_clears;
   int n_ends;
   int n_hits;

   // Directed stimulus table
   typedef struct {
      logic [bpnfa_pkg::FUNC_W-1:0]   func;
      logic [bpnfa_pkg::STATE_W-1:0]  sa;
      logic [bpnfa_pkg::STATE_W-1:0]  sb;
      logic [bpnfa_pkg::SYMBOL_W-1:0] sym;
      bit                             pinned;
      bpnfa_pkg::result_type          want;
   } dir_row_type;

   dir_row_type dir_rows [24] = '{
      // nothing loaded: end, symbol, unused code and start all see an empty set
      '{bpnfa_pkg::FUNC_END,       8'd0,   8'd0,   4'd0,  1'b1, RES_EMPTY},
      '{bpnfa_pkg::FUNC_SYMBOL,    8'd0,   8'd0,   4'd15, 1'b1, RES_EMPTY},
      '{FUNC_UNUSED,               8'd255, 8'd255, 4'd15, 1'b1, RES_EMPTY},
      '{bpnfa_pkg::FUNC_START,     8'd0,   8'd0,   4'd0,  1'b1, RES_EMPTY},
      // loads at the extreme states and symbols; current set stays empty
      '{bpnfa_pkg::FUNC_SET_INIT,  8'd0,   8'd0,   4'd0,  1'b1, RES_EMPTY},
      '{bpnfa_pkg::FUNC_SET_INIT,  8'd255, 8'd0,   4'd0,  1'b1, RES_EMPTY},
      '{bpnfa_pkg::FUNC_SET_FINAL, 8'd255, 8'd0,   4'd0,  1'b1, RES_EMPTY},
      '{bpnfa_pkg::FUNC_SET_TRANS, 8'd0,   8'd255, 4'd0,  1'b1, RES_EMPTY},
      '{bpnfa_pkg::FUNC_SET_TRANS, 8'd255, 8'd0,   4'd15, 1'b1, RES_EMPTY},
      '{bpnfa_pkg::FUNC_SET_TRANS, 8'd255, 8'd128, 4'd15, 1'b1, RES_EMPTY},
      // sample: initial {0,255}, state 255 final
      '{bpnfa_pkg::FUNC_START,     8'd0,   8'd0,   4'd0,  1'b1, RES_ACTIVE},
      '{bpnfa_pkg::FUNC_END,       8'd0,   8'd0,   4'd0,  1'b1, RES_HIT},
      '{bpnfa_pkg::FUNC_SYMBOL,    8'd0,   8'd0,   4'd0,  1'b0, RES_EMPTY},
      // load in the middle of a sample
      '{bpnfa_pkg::FUNC_SET_FINAL, 8'd0,   8'd0,   4'd0,  1'b0, RES_EMPTY},
      '{bpnfa_pkg::FUNC_SYMBOL,    8'd0,   8'd0,   4'd15, 1'b0, RES_EMPTY},
      '{bpnfa_pkg::FUNC_END,       8'd0,   8'd0,   4'd0,  1'b0, RES_EMPTY},
      // no successors: set dies and stays dead (early reject)
      '{bpnfa_pkg::FUNC_SYMBOL,    8'd0,   8'd0,   4'd7,  1'b0, RES_EMPTY},
      '{bpnfa_pkg::FUNC_SYMBOL,    8'd0,   8'd0,   4'd0,  1'b0, RES_EMPTY},
      '{bpnfa_pkg::FUNC_END,       8'd0,   8'd0,   4'd0,  1'b0, RES_EMPTY},
      '{bpnfa_pkg::FUNC_SET_TRANS, 8'haa,  8'h55,  4'ha,  1'b0, RES_EMPTY},
      '{bpnfa_pkg::FUNC_SET_TRANS, 8'h55,  8'haa,  4'h5,  1'b0, RES_EMPTY},
      // clear all wipes initial and final too
      '{bpnfa_pkg::FUNC_CLEAR_ALL, 8'd0,   8'd0,   4'd0,  1'b1, RES_EMPTY},
      '{bpnfa_pkg::FUNC_START,     8'd0,   8'd0,   4'd0,  1'b1, RES_EMPTY},
      '{bpnfa_pkg::FUNC_END,       8'd0,   8'd0,   4'd0,  1'b1, RES_EMPTY}
   };

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   initial begin
      #40_000_000;
      $display("bit_parallel_nfa_matcher_core: mismatch");
      $finish;
   end

   // Random field values
   function automatic logic [bpnfa_pkg::STATE_W-1:0] rnd_state();
      return bpnfa_pkg::STATE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [bpnfa_pkg::SYMBOL_W-1:0] rnd_sym();
      return bpnfa_pkg::SYMBOL_W'($urandom_range(0, 15));
   endfunction

   // Apply one request to the predictor state and return the response it owes
   function automatic bpnfa_pkg::result_type nfa_advance(
         input logic [bpnfa_pkg::FUNC_W-1:0]   f,
         input logic [bpnfa_pkg::STATE_W-1:0]  sa,
         input logic [bpnfa_pkg::STATE_W-1:0]  sb,
         input logic [bpnfa_pkg::SYMBOL_W-1:0] sym);
      bpnfa_pkg::result_type r;
      logic [NSTATES-1:0]    nxt;
      int                    st;
      r.match = 1'b0;
      case (f)
         bpnfa_pkg::FUNC_SET_TRANS: succ_rows[int'(sa) * NSYMS + int'(sym)][sb] = 1'b1;
         bpnfa_pkg::FUNC_SET_INIT:  init_set[sa] = 1'b1;
         bpnfa_pkg::FUNC_SET_FINAL: final_set[sa] = 1'b1;
         bpnfa_pkg::FUNC_CLEAR_ALL: begin
            for (st = 0; st < NSTATES * NSYMS; st++) succ_rows[st] = '0;
            init_set  = '0;
            final_set = '0;
            cur_set   = '0;
         end
         bpnfa_pkg::FUNC_START: cur_set = init_set;
         bpnfa_pkg::FUNC_SYMBOL: begin
            nxt = '0;
            for (st = 0; st < NSTATES; st++)
               if (cur_set[st]) nxt |= succ_rows[st * NSYMS + int'(sym)];
            cur_set = nxt;
         end
         bpnfa_pkg::FUNC_END: r.match = |(cur_set & final_set);
         default: ;
      endcase
      r.any_active = |cur_set;
      return r;
   endfunction

   // Request acceptance and response checking, sampled at the rising edge
   always @(posedge clock) begin
      bpnfa_pkg::result_type want;
      bpnfa_pkg::result_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = nfa_advance(req_func, req_state_a, req_state_b, req_symbol);
            if (pin_flag) want = pin_want;
            pending_rsp_q.push_back(want);
            n_requests++;
            if (req_func == bpnfa_pkg::FUNC_SYMBOL) n_sym_steps++;
            if (req_func == bpnfa_pkg::FUNC_CLEAR_ALL) n_clears++;
            if (req_func == bpnfa_pkg::FUNC_END) n_ends++;
         end
         if (rsp_valid && rsp_ready) begin
            n_responses++;
            got.match      = rsp_match;
            got.any_active = rsp_any_active;
            if (got.match) n_hits++;
            if (pending_rsp_q.size() == 0) begin
               $error("response with no request outstanding: match=%0b any_active=%0b",
                      got.match, got.any_active);
               fail_count++;
            end else begin
               want = pending_rsp_q.pop_front();
               if (got.match !== want.match) begin
                  $error("match: expected %0b, got %0b", want.match, got.match);
                  fail_count++;
               end
               if (got.any_active !== want.any_active) begin
                  $error("any_active: expected %0b, got %0b",
                         want.any_active, got.any_active);
                  fail_count++;
               end
            end
         end
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
   end

   // Drive one request at the falling edge and hold it until accepted
   task automatic send_req(input logic [bpnfa_pkg::FUNC_W-1:0]   f,
                           input logic [bpnfa_pkg::STATE_W-1:0]  sa,
                           input logic [bpnfa_pkg::STATE_W-1:0]  sb,
                           input logic [bpnfa_pkg::SYMBOL_W-1:0] sym,
                           input bit pinned, input bpnfa_pkg::result_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      pin_flag    = pinned;
      pin_want    = want;
      req_valid   <= 1'b1;
      req_func    <= f;
      req_state_a <= sa;
      req_state_b <= sb;
      req_symbol  <= sym;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic send_op(input logic [bpnfa_pkg::FUNC_W-1:0]   f,
                          input logic [bpnfa_pkg::STATE_W-1:0]  sa,
                          input logic [bpnfa_pkg::STATE_W-1:0]  sb,
                          input logic [bpnfa_pkg::SYMBOL_W-1:0] sym);
      send_req(f, sa, sb, sym, 1'b0, RES_EMPTY);
   endtask

   // Random episodes: load a small automaton, run a sample over it, add noise.
   // A small state pool and few symbols keep the current set alive for a while.
   task automatic run_episodes(input int n_items);
      logic [bpnfa_pkg::STATE_W-1:0]  pool [6];
      logic [bpnfa_pkg::SYMBOL_W-1:0] syms [3];
      logic [bpnfa_pkg::FUNC_W-1:0]   f;
      int                             first;
      int                             broken;
      int                             i;
      first = sent_count;
      while (sent_count - first < n_items) begin
         for (i = 0; i < 6; i++) pool[i] = rnd_state();
         for (i = 0; i < 3; i++) syms[i] = rnd_sym();
         if ($urandom_range(0, 5) == 0)
            send_op(bpnfa_pkg::FUNC_CLEAR_ALL, 8'd0, 8'd0, 4'd0);
         repeat ($urandom_range(3, 8))
            send_op(bpnfa_pkg::FUNC_SET_TRANS, pool[$urandom_range(0, 5)],
                    pool[$urandom_range(0, 5)], syms[$urandom_range(0, 2)]);
         repeat ($urandom_range(1, 2))
            send_op(bpnfa_pkg::FUNC_SET_INIT, pool[$urandom_range(0, 5)], rnd_state(),
                    rnd_sym());
         repeat ($urandom_range(1, 2))
            send_op(bpnfa_pkg::FUNC_SET_FINAL, pool[$urandom_range(0, 5)], rnd_state(),
                    rnd_sym());
         // broken == 0 drops the start, broken == 1 drops the end
         broken = $urandom_range(0, 9);
         if (broken != 0) send_op(bpnfa_pkg::FUNC_START, rnd_state(), rnd_state(),
                                  rnd_sym());
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 9) == 0)
               send_op(bpnfa_pkg::FUNC_SET_TRANS, pool[$urandom_range(0, 5)],
                       pool[$urandom_range(0, 5)], syms[$urandom_range(0, 2)]);
            else if ($urandom_range(0, 9) == 0)
               send_op(bpnfa_pkg::FUNC_SYMBOL, rnd_state(), rnd_state(), rnd_sym());
            else
               send_op(bpnfa_pkg::FUNC_SYMBOL, rnd_state(), rnd_state(),
                       syms[$urandom_range(0, 2)]);
         end
         if (broken != 1) send_op(bpnfa_pkg::FUNC_END, rnd_state(), rnd_state(),
                                  rnd_sym());
         // noise; clears are kept to the episode start since each sweeps the whole successor table
         if ($urandom_range(0, 4) == 0) begin
            f = bpnfa_pkg::FUNC_W'($urandom_range(0, 7));
            if (f == bpnfa_pkg::FUNC_CLEAR_ALL) f = bpnfa_pkg::FUNC_END;
            send_op(f, rnd_state(), rnd_state(), rnd_sym());
         end
      end
   endtask

   // Main sequence
   initial begin
      int k;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = bpnfa_pkg::FUNC_SET_TRANS;
      req_state_a   = '0;
      req_state_b   = '0;
      req_symbol    = '0;
      pin_flag      = 1'b0;
      pin_want      = RES_EMPTY;
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      sent_count    = 0;
      fail_count    = 0;
      n_requests    = 0;
      n_responses   = 0;
      n_sym_steps   = 0;
      n_clears      = 0;
      n_ends        = 0;
      n_hits        = 0;
      for (k = 0; k < NSTATES * NSYMS; k++) succ_rows[k] = '0;
      init_set  = '0;
      final_set = '0;
      cur_set   = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      send_idle_pct = 37;
      rcv_idle_pct  = 54;
      for (k = 0; k < 24; k++)
         send_req(dir_rows[k].func, dir_rows[k].sa, dir_rows[k].sb, dir_rows[k].sym,
                  dir_rows[k].pinned, dir_rows[k].want);

      // random part in three idling phases
      run_episodes(180);
      send_idle_pct = 54;
      rcv_idle_pct  = 37;
      run_episodes(180);
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      run_episodes(180);

      @(negedge clock);
      req_valid <= 1'b0;

      // drain
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d requests: %0d symbol steps, %0d clears, %0d sample ends.",
               n_requests, n_sym_steps, n_clears, n_ends);
      $display("Checked %0d responses, %0d with the final set hit.", n_responses, n_hits);
      if (fail_count == 0 && pending_rsp_q.size() == 0)
         $display("bit_parallel_nfa_matcher_core: match");
      else
         $display("bit_parallel_nfa_matcher_core: mismatch");
      $finish;
   end

endmodule
